// File: rtl/ccfl_pkg.sv
// shared types and constants for the checksummed command and frame loader
// no dependencies
package ccfl_pkg;

  localparam int FRAME_WIDTH  = 128;
  localparam int FRAME_HEIGHT = 64;
  localparam int FRAME_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int CNT_W        = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
  localparam int ADDR_W       = 13;

  localparam logic [CNT_W-1:0] LAST_PIXEL = CNT_W'(FRAME_SIZE - 1);

  localparam logic [31:0] WORD_ACK   = 32'hDEADBEEF;
  localparam logic [31:0] WORD_FRAME = 32'h00FEED00;
  localparam logic [2:0]  CMD_LAST   = 3'd4;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_CHECKSUM = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

  localparam logic [2:0] BLINK_NONE    = 3'd0;
  localparam logic [2:0] BLINK_ACK     = 3'd1;
  localparam logic [2:0] BLINK_BAD_SUM = 3'd3;
  localparam logic [2:0] BLINK_UNKNOWN = 3'd4;
  localparam logic [2:0] BLINK_FRAME   = 3'd5;

  typedef struct packed {
    logic              receiving_frame;
    logic [2:0]        cmd_count;
    logic [31:0]       cmd_word;
    logic [7:0]        running_sum;
    logic [ADDR_W-1:0] frame_position;
    logic [CNT_W-1:0]  pixel_count;
    logic [1:0]        latched_error;
  } state_t;

  typedef struct packed {
    logic              pixel_write;
    logic [ADDR_W-1:0] pixel_address;
    logic [7:0]        pixel_value;
    logic              frame_done;
    logic              command_done;
    logic [1:0]        error_code;
    logic [2:0]        blink_count;
    logic              frame_mode;
  } result_t;

endpackage

// File: rtl/ccfl_step.sv
// per-byte next-state and result logic
// depends on ccfl_pkg
module ccfl_step (
  input  ccfl_pkg::state_t  cur,
  input  logic [7:0]        rx_byte,
  output ccfl_pkg::state_t  nxt,
  output ccfl_pkg::result_t res
);

  always_comb begin
    nxt = cur;
    res = '0;
    if (cur.receiving_frame) begin
      res.pixel_write    = 1'b1;
      res.pixel_address  = cur.frame_position;
      res.pixel_value    = rx_byte;
      nxt.frame_position = cur.frame_position + 1'b1;
      nxt.pixel_count    = cur.pixel_count + 1'b1;
      if (cur.pixel_count == ccfl_pkg::LAST_PIXEL) begin
        res.frame_done      = 1'b1;
        res.blink_count     = ccfl_pkg::BLINK_ACK;
        nxt.receiving_frame = 1'b0;
        nxt.pixel_count     = '0;
        nxt.frame_position  = '0;
      end
    end else if (cur.cmd_count != ccfl_pkg::CMD_LAST) begin
      nxt.cmd_word    = {cur.cmd_word[23:0], rx_byte};
      nxt.running_sum = cur.running_sum + rx_byte;
      nxt.cmd_count   = cur.cmd_count + 1'b1;
    end else begin
      res.command_done = 1'b1;
      if (rx_byte != cur.running_sum) begin
        nxt.latched_error = ccfl_pkg::ERR_CHECKSUM;
        res.blink_count   = ccfl_pkg::BLINK_BAD_SUM;
      end else if (cur.cmd_word == ccfl_pkg::WORD_ACK) begin
        nxt.latched_error = ccfl_pkg::ERR_NONE;
        res.blink_count   = ccfl_pkg::BLINK_ACK;
      end else if (cur.cmd_word == ccfl_pkg::WORD_FRAME) begin
        nxt.latched_error   = ccfl_pkg::ERR_NONE;
        nxt.receiving_frame = 1'b1;
        nxt.frame_position  = '0;
        nxt.pixel_count     = '0;
        res.blink_count     = ccfl_pkg::BLINK_FRAME;
      end else begin
        nxt.latched_error = ccfl_pkg::ERR_UNKNOWN;
        res.blink_count   = ccfl_pkg::BLINK_UNKNOWN;
      end
      nxt.cmd_count   = '0;
      nxt.cmd_word    = '0;
      nxt.running_sum = '0;
    end
    res.error_code = nxt.latched_error;
    res.frame_mode = nxt.receiving_frame;
  end

endmodule

// File: rtl/checksummed_command_and_frame_loader.sv
// latency: a result is valid in the cycle after its byte's transaction
// throughput: one byte per cycle, the output register is reloaded on the
// same edge it is taken, so ready only drops while a result is stalled
// reset: synchronous rst clears mode, command gathering, frame position,
// latched error and the output valid flag
module checksummed_command_and_frame_loader (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          pixel_write,
  output logic [ccfl_pkg::ADDR_W-1:0]   pixel_address,
  output logic [7:0]                    pixel_value,
  output logic                          frame_done,
  output logic                          command_done,
  output logic [1:0]                    error_code,
  output logic [2:0]                    blink_count,
  output logic                          frame_mode
);

  ccfl_pkg::state_t  state;
  ccfl_pkg::state_t  state_next;
  ccfl_pkg::result_t step_res;
  ccfl_pkg::result_t result;
  logic              accept;

  ccfl_step u_step (
    .cur     (state),
    .rx_byte (rx_byte),
    .nxt     (state_next),
    .res     (step_res)
  );

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= state_next;
      end
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= step_res;
    end
  end

  assign pixel_write   = result.pixel_write;
  assign pixel_address = result.pixel_address;
  assign pixel_value   = result.pixel_value;
  assign frame_done    = result.frame_done;
  assign command_done  = result.command_done;
  assign error_code    = result.error_code;
  assign blink_count   = result.blink_count;
  assign frame_mode    = result.frame_mode;

endmodule

// File: rtl/ccfl_checker.sv
// port-level checks for the checksummed command and frame loader
// depends on ccfl_pkg, bound to the top level
module ccfl_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        pixel_write,
  input logic [ccfl_pkg::ADDR_W-1:0] pixel_address,
  input logic [7:0]                  pixel_value,
  input logic                        frame_done,
  input logic                        command_done,
  input logic [1:0]                  error_code,
  input logic [2:0]                  blink_count,
  input logic                        frame_mode
);

  // a pixel that does not end the frame leaves frame mode on
  a_pixel_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_write && !frame_done |-> frame_mode)
    else $error("pixel write outside frame mode");

  // frame end returns to command mode with one blink
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> pixel_write && !frame_mode
      && blink_count == ccfl_pkg::BLINK_ACK)
    else $error("bad frame end result");

  // pixel fields are zero without a pixel write
  a_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_write |-> pixel_address == '0 && pixel_value == '0)
    else $error("pixel fields set without write");

  // entering frame mode is a clean completed command
  a_enter_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && blink_count == ccfl_pkg::BLINK_FRAME |->
      command_done && frame_mode && error_code == ccfl_pkg::ERR_NONE)
    else $error("bad frame mode entry");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_address)
      && $stable(blink_count) && $stable(error_code))
    else $error("stalled result changed");

endmodule

bind checksummed_command_and_frame_loader ccfl_checker u_ccfl_checker (.*);
